/* rtl/tch_pkg.sv */
// tch_pkg: shared constants, types and tables for the tilt-compensated heading block
// no dependencies
`default_nettype none

package tch_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int CORDIC_STAGES = 18;
   localparam int TAB_LEN       = 24;
   localparam int STG_BITS      = $clog2(CORDIC_STAGES);

   // vector datapath width, wide enough for Q30 times two samples plus gain
   localparam int VW = 2 * SAMPLE_BITS + 36;
   // angle width, units of 2^-20 degree
   localparam int AW = 32;

   localparam logic signed [VW-1:0] ONE_Q30      = VW'(64'sd1073741824);
   localparam logic signed [VW-1:0] GAIN_Q30     = VW'(64'sd1768195363);
   localparam logic signed [VW-1:0] INV_GAIN_Q30 = VW'(64'sd652032874);
   localparam logic signed [AW-1:0] A90  = AW'(64'sd94371840);
   localparam logic signed [AW-1:0] A180 = AW'(64'sd188743680);
   localparam logic signed [AW-1:0] A360 = AW'(64'sd377487360);

   localparam int HEADING_WRAP = 23040;
   localparam int PITCH_MAX    = 5760;
   localparam int ROLL_MAX     = 11520;
   localparam int BUBBLE_DIV   = 1152;
   localparam int BUBBLE_ONE   = 16384;

   // atan(2^-i) in 2^-20 degree
   function automatic logic signed [AW-1:0] atan_tab(input int i);
      logic signed [AW-1:0] r;
      case (i)
         0: r = 47185920;  1: r = 27855475;  2: r = 14718068;  3: r = 7471121;
         4: r = 3750058;   5: r = 1876857;   6: r = 938658;    7: r = 469357;
         8: r = 234682;    9: r = 117342;    10: r = 58671;    11: r = 29335;
         12: r = 14668;    13: r = 7334;     14: r = 3667;     15: r = 1833;
         16: r = 917;      17: r = 458;      18: r = 229;      19: r = 115;
         20: r = 57;       21: r = 29;       22: r = 14;       23: r = 7;
         default: r = '0;
      endcase
      return r;
   endfunction

   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [AW-1:0] ang_type;

   typedef enum logic {
      MODE_VECTOR = 1'b0,
      MODE_ROTATE = 1'b1
   } cordic_mode_type;

   // values carried alongside the cordic chains
   // zero marks a zero input vector of the vectoring chain it rides through
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] ax;
      logic signed [SAMPLE_BITS-1:0] mx;
      logic signed [SAMPLE_BITS-1:0] my;
      logic signed [SAMPLE_BITS-1:0] mz;
      ang_type roll;
      ang_type pitch;
      vec_type cr;
      vec_type sr;
      vec_type cp;
      vec_type sp;
      logic    zero;
   } side_type;

endpackage

`default_nettype wire

/* rtl/tch_stream_if.sv */
// tch_stream_if: valid/ready channels for the sample item and the result item
// depends on tch_pkg for payload types
`default_nettype none

interface tch_req_if;
   import tch_pkg::*;
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] accel_x, accel_y, accel_z, mag_x, mag_y, mag_z;
   modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                   output ready);
endinterface

interface tch_rsp_if;
   logic valid;
   logic ready;
   logic [14:0]        heading;
   logic signed [13:0] pitch_angle;
   logic signed [14:0] roll_angle;
   logic signed [15:0] bubble_x;
   logic signed [15:0] bubble_y;
   modport source (output valid, heading, pitch_angle, roll_angle, bubble_x, bubble_y,
                   input ready);
   modport sink   (input valid, heading, pitch_angle, roll_angle, bubble_x, bubble_y,
                   output ready);
endinterface

`default_nettype wire

/* rtl/tch_cell.sv */
// tch_cell: one cordic micro-rotation cell, vectoring or rotation mode
// depends on tch_pkg
`default_nettype none

module tch_cell
   import tch_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            en,
   input  wire cordic_mode_type mode,
   input  wire logic [STG_BITS-1:0] stage,
   input  wire vec_type         x_i,
   input  wire vec_type         y_i,
   input  wire ang_type         z_i,
   output vec_type              x_o,
   output vec_type              y_o,
   output ang_type              z_o
);
   vec_type x_ff, y_ff, x_in, y_in;
   ang_type z_ff, z_in;
   vec_type dx, dy;
   logic    pos;

   // arithmetic shift equals floor shift
   always_comb begin
      dx  = x_i >>> stage;
      dy  = y_i >>> stage;
      pos = (mode == MODE_VECTOR) ? (y_i >= 0) : (z_i < 0);
      if (pos) begin
         x_in = x_i + (y_i >>> stage);
         y_in = y_i - dx;
         z_in = z_i + atan_tab(int'(stage));
      end else begin
         x_in = x_i - (y_i >>> stage);
         y_in = y_i + dx;
         z_in = z_i - atan_tab(int'(stage));
      end
      if (mode == MODE_ROTATE) begin
         // rotation direction is the mirror image of vectoring
         if (!pos) begin
            x_in = x_i - (y_i >>> stage);
            y_in = y_i + dx;
            z_in = z_i - atan_tab(int'(stage));
         end else begin
            x_in = x_i + (y_i >>> stage);
            y_in = y_i - dx;
            z_in = z_i + atan_tab(int'(stage));
         end
      end
   end

   // stage register, advances with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
   logic unused_dy;
   assign unused_dy = ^dy;
endmodule

`default_nettype wire

/* rtl/tch_chain.sv */
// tch_chain: row of cordic cells, carries side values beside the vector
// depends on tch_pkg and tch_cell
`default_nettype none

module tch_chain
   import tch_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            en,
   input  wire cordic_mode_type mode,
   input  wire vec_type         x_i,
   input  wire vec_type         y_i,
   input  wire ang_type         z_i,
   input  wire side_type        side_i,
   output vec_type              x_o,
   output vec_type              y_o,
   output ang_type              z_o,
   output side_type             side_o
);
   vec_type  xs [CORDIC_STAGES+1];
   vec_type  ys [CORDIC_STAGES+1];
   ang_type  zs [CORDIC_STAGES+1];
   side_type ss_ff [CORDIC_STAGES];

   assign xs[0] = x_i;
   assign ys[0] = y_i;
   assign zs[0] = z_i;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      tch_cell u_cell (
         .clock (clock), .en (en), .mode (mode),
         .stage (STG_BITS'(g)),
         .x_i (xs[g]), .y_i (ys[g]), .z_i (zs[g]),
         .x_o (xs[g+1]), .y_o (ys[g+1]), .z_o (zs[g+1])
      );
      // side values ride along with each cell
      always_ff @(posedge clock) begin
         if (en) ss_ff[g] <= (g == 0) ? side_i : ss_ff[(g == 0) ? 0 : g-1];
      end
   end

   assign x_o    = xs[CORDIC_STAGES];
   assign y_o    = ys[CORDIC_STAGES];
   assign z_o    = zs[CORDIC_STAGES];
   assign side_o = ss_ff[CORDIC_STAGES-1];
endmodule

`default_nettype wire

/* rtl/tilt_compensated_heading.sv */
// tilt_compensated_heading: top level, five cordic chains and glue stages
// depends on tch_pkg, tch_stream_if, tch_chain
// pipeline: capture stage, five cell chains with registered glue stages between, output register
// throughput: one item per cycle while results are taken, set by the fully pipelined cell chains
// the whole pipeline stalls together when the result is not taken
// reset clears only the valid bits of the stages; payloads are not reset
`default_nettype none

module tilt_compensated_heading
   import tch_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tch_req_if.sink   req,
   tch_rsp_if.source rsp
);
   localparam int LAT = 5 * CORDIC_STAGES + 8;

   // bubble scaling: 1152 = 128 * 9, the divide by 9 is a reciprocal multiply
   localparam int BUBBLE_SAT = BUBBLE_ONE * BUBBLE_DIV + BUBBLE_DIV / 2;
   localparam int RECIP_9    = 233017;   // ceil(2^21 / 9), exact for 18-bit operands

   logic en;
   logic [LAT-1:0] v_ff;

   // signed 32 by 32 multiply, widened to the vector datapath
   function automatic vec_type mul_32x32(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return vec_type'(p);
   endfunction

   // whole pipe advances unless the output is full and held
   assign en        = !v_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[LAT-2:0], req.valid};
   end

   // stage 0: capture and set up roll atan2 with quadrant fix
   side_type s0_ff;
   vec_type  x0_ff, y0_ff;
   ang_type  z0_ff;
   always_ff @(posedge clock) begin
      vec_type  x, y;
      side_type s;
      if (en) begin
         x      = vec_type'(req.accel_z) <<< 30;
         y      = vec_type'(req.accel_y) <<< 30;
         s      = '0;
         s.ax   = req.accel_x;
         s.mx   = req.mag_x;
         s.my   = req.mag_y;
         s.mz   = req.mag_z;
         s.zero = (x == 0) && (y == 0);
         s0_ff <= s;
         if (x < 0) begin
            x0_ff <= -x; y0_ff <= -y; z0_ff <= (y >= 0) ? A180 : -A180;
         end else begin
            x0_ff <= x; y0_ff <= y; z0_ff <= '0;
         end
      end
   end

   // roll chain
   vec_type x1, y1; ang_type z1; side_type s1;
   tch_chain u_roll (.clock(clock), .en(en), .mode(MODE_VECTOR),
      .x_i(x0_ff), .y_i(y0_ff), .z_i(z0_ff), .side_i(s0_ff),
      .x_o(x1), .y_o(y1), .z_o(z1), .side_o(s1));

   // zero vector gives zero roll and zero length
   // pitch setup: kr is nonnegative, so no quadrant fix needed
   side_type s2_ff; vec_type x2_ff, y2_ff;
   always_ff @(posedge clock) begin
      side_type s;
      if (en) begin
         s      = s1;
         s.roll = s1.zero ? '0 : z1;
         s2_ff <= s;
         x2_ff <= s1.zero ? '0 : x1;
         y2_ff <= -mul_32x32(32'(s1.ax), 32'(GAIN_Q30));
      end
   end

   vec_type x3, y3; ang_type z3; side_type s3;
   tch_chain u_pitch (.clock(clock), .en(en), .mode(MODE_VECTOR),
      .x_i(x2_ff), .y_i(y2_ff), .z_i('0), .side_i(s2_ff),
      .x_o(x3), .y_o(y3), .z_o(z3), .side_o(s3));

   // roll sincos setup with half-turn fold
   // zero length and zero ax is a zero vector, so pitch is zero
   side_type s4_ff; ang_type z4_ff; logic f4_ff;
   always_ff @(posedge clock) begin
      side_type s;
      if (en) begin
         s       = s3;
         s.pitch = (s3.zero && (s3.ax == 0)) ? '0 : z3;
         s4_ff  <= s;
         f4_ff  <= (s3.roll > A90) || (s3.roll < -A90);
         z4_ff  <= (s3.roll > A90) ? s3.roll - A180 :
                   (s3.roll < -A90) ? s3.roll + A180 : s3.roll;
      end
   end

   vec_type x5, y5; ang_type z5; side_type s5;
   tch_chain u_rsc (.clock(clock), .en(en), .mode(MODE_ROTATE),
      .x_i(INV_GAIN_Q30), .y_i('0), .z_i(z4_ff), .side_i(s4_ff),
      .x_o(x5), .y_o(y5), .z_o(z5), .side_o(s5));

   // fold flag delay line for roll
   logic [CORDIC_STAGES-1:0] f4d_ff;
   always_ff @(posedge clock)
      if (en) f4d_ff <= {f4d_ff[CORDIC_STAGES-2:0], f4_ff};

   side_type s6_ff; ang_type z6_ff; logic f6_ff;
   always_ff @(posedge clock) begin
      side_type s;
      if (en) begin
         s      = s5;
         s.cr   = f4d_ff[CORDIC_STAGES-1] ? -x5 : x5;
         s.sr   = f4d_ff[CORDIC_STAGES-1] ? -y5 : y5;
         s6_ff <= s;
         f6_ff <= (s5.pitch > A90) || (s5.pitch < -A90);
         z6_ff <= (s5.pitch > A90) ? s5.pitch - A180 :
                  (s5.pitch < -A90) ? s5.pitch + A180 : s5.pitch;
      end
   end

   vec_type x7, y7; ang_type z7; side_type s7;
   tch_chain u_psc (.clock(clock), .en(en), .mode(MODE_ROTATE),
      .x_i(INV_GAIN_Q30), .y_i('0), .z_i(z6_ff), .side_i(s6_ff),
      .x_o(x7), .y_o(y7), .z_o(z7), .side_o(s7));

   logic [CORDIC_STAGES-1:0] f6d_ff;
   always_ff @(posedge clock)
      if (en) f6d_ff <= {f6d_ff[CORDIC_STAGES-2:0], f6_ff};

   // products: sin/cos cross terms, Q30 values fit in 32 bits
   side_type s8_ff; vec_type srsp8_ff, srcp8_ff;
   always_ff @(posedge clock) begin
      vec_type  c, s;
      side_type t;
      if (en) begin
         c    = f6d_ff[CORDIC_STAGES-1] ? -x7 : x7;
         s    = f6d_ff[CORDIC_STAGES-1] ? -y7 : y7;
         t    = s7;
         t.cp = c;
         t.sp = s;
         s8_ff    <= t;
         srsp8_ff <= mul_32x32(32'(s7.sr), 32'(s)) >>> 30;
         srcp8_ff <= mul_32x32(32'(s7.sr), 32'(c)) >>> 30;
      end
   end

   // tilt compensation multiplies
   side_type s9_ff; vec_type a9_ff, b9_ff, c9_ff, d9_ff, e9_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s9_ff <= s8_ff;
         a9_ff <= mul_32x32(32'(s8_ff.mx), 32'(s8_ff.cp));
         b9_ff <= mul_32x32(32'(s8_ff.mz), 32'(s8_ff.sp));
         c9_ff <= mul_32x32(32'(s8_ff.mx), 32'(srsp8_ff));
         d9_ff <= mul_32x32(32'(s8_ff.my), 32'(s8_ff.cr));
         e9_ff <= mul_32x32(32'(s8_ff.mz), 32'(srcp8_ff));
      end
   end

   // heading setup: atan2(-my2, mx2), zero vector flagged
   side_type s10_ff; vec_type x10_ff, y10_ff; ang_type z10_ff;
   always_ff @(posedge clock) begin
      vec_type  x, y;
      side_type s;
      if (en) begin
         x      = a9_ff + b9_ff;
         y      = -(c9_ff + d9_ff - e9_ff);
         s      = s9_ff;
         s.zero = (x == 0) && (y == 0);
         s10_ff <= s;
         if (x < 0) begin
            x10_ff <= -x; y10_ff <= -y; z10_ff <= (y >= 0) ? A180 : -A180;
         end else begin
            x10_ff <= x; y10_ff <= y; z10_ff <= '0;
         end
      end
   end

   vec_type x11, y11; ang_type z11; side_type s11;
   tch_chain u_head (.clock(clock), .en(en), .mode(MODE_VECTOR),
      .x_i(x10_ff), .y_i(y10_ff), .z_i(z10_ff), .side_i(s10_ff),
      .x_o(x11), .y_o(y11), .z_o(z11), .side_o(s11));

   // output rounding and bubble scaling
   function automatic ang_type rnd(input ang_type a);
      return (a + 8192) >>> 14;
   endfunction

   // magnitude rounded to nearest over 1152, saturated at one
   function automatic logic signed [15:0] bub(input ang_type a);
      logic [AW-1:0] m;
      logic [17:0]   t;
      logic [35:0]   p;
      logic [15:0]   q;
      m = (a < 0) ? AW'(-a) : AW'(a);
      if (m >= AW'(BUBBLE_SAT)) begin
         q = 16'(BUBBLE_ONE);
      end else begin
         t = 18'((m + AW'(BUBBLE_DIV / 2)) >> 7);
         p = t * 18'(RECIP_9);
         q = 16'(p >> 21);
      end
      return (a < 0) ? -q : q;
   endfunction

   logic [14:0] hd_ff; logic signed [13:0] pa_ff; logic signed [14:0] ra_ff;
   logic signed [15:0] bx_ff, by_ff;
   always_ff @(posedge clock) begin
      ang_type h, hq, pq, rq;
      if (en) begin
         h  = s11.zero ? '0 : (z11 < 0) ? z11 + A360 : z11;
         hq = rnd(h);
         if (hq >= HEADING_WRAP) hq = hq - HEADING_WRAP;
         if (hq < 0) hq = '0;
         pq = rnd(s11.pitch);
         pq = (pq > PITCH_MAX) ? PITCH_MAX : (pq < -PITCH_MAX) ? -PITCH_MAX : pq;
         rq = rnd(s11.roll);
         rq = (rq > ROLL_MAX) ? ROLL_MAX : (rq < -ROLL_MAX) ? -ROLL_MAX : rq;
         hd_ff <= 15'(hq);
         pa_ff <= 14'(pq);
         ra_ff <= 15'(rq);
         bx_ff <= bub(s11.roll);
         by_ff <= bub(s11.pitch);
      end
   end

   assign rsp.valid       = v_ff[LAT-1];
   assign rsp.heading     = hd_ff;
   assign rsp.pitch_angle = pa_ff;
   assign rsp.roll_angle  = ra_ff;
   assign rsp.bubble_x    = bx_ff;
   assign rsp.bubble_y    = by_ff;

   logic unused_ok;
   assign unused_ok = ^{y1, x3, y3, z5, z7, x11, y11, s11};
endmodule

`default_nettype wire

/* test/tilt_compensated_heading_test.sv */
// tilt_compensated_heading_test: self-checking bench for the tilt-compensated heading block
// depends on tch_pkg, tch_stream_if and tilt_compensated_heading from the rtl folder
`default_nettype none

module tilt_compensated_heading_test
   import tch_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 5 * CORDIC_STAGES + 8;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic [14:0]        heading;
      logic signed [13:0] pitch_angle;
      logic signed [14:0] roll_angle;
      logic signed [15:0] bubble_x;
      logic signed [15:0] bubble_y;
   } attitude_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle = 0;
   int   mismatches = 0;

   attitude_type attitude_queue[$];

   tch_req_if req();
   tch_rsp_if rsp();

   tilt_compensated_heading dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // arithmetic shift right rounding toward minus infinity
   function automatic longint floor_sra(longint v, int s);
      return v >>> s;
   endfunction

   // vectoring cordic, returns angle in 2^-20 degree and scaled length
   function automatic longint vector_angle(longint x, longint y, output longint len);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? longint'(A180) : -longint'(A180);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
         dx = floor_sra(y, i);
         dy = floor_sra(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_tab(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_tab(i));
         end
      end
      len = x;
      return z;
   endfunction

   // rotation cordic, cos and sin in Q30
   function automatic void rotate_unit(longint z, output longint c, output longint s);
      logic   flip;
      longint x, y, dx, dy;
      flip = 1'b0;
      x = longint'(INV_GAIN_Q30);
      y = 0;
      if (z > longint'(A90)) begin
         z -= longint'(A180); flip = 1'b1;
      end else if (z < -longint'(A90)) begin
         z += longint'(A180); flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
         dx = floor_sra(y, i);
         dy = floor_sra(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_tab(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_tab(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic longint level_of(longint a);
      longint q;
      q = (a >= 0) ? (a + BUBBLE_DIV / 2) / BUBBLE_DIV : -((-a + BUBBLE_DIV / 2) / BUBBLE_DIV);
      return clamp_sym(q, BUBBLE_ONE);
   endfunction

   // expected attitude and heading for one sample
   function automatic attitude_type predict_attitude(longint ax, longint ay, longint az,
                                                     longint mx, longint my, longint mz);
      attitude_type r;
      longint kr, junk, roll, pitch, cr, sr, cp, sp, srsp, srcp, mx2, my2, h, hq;
      roll  = vector_angle(az * longint'(ONE_Q30), ay * longint'(ONE_Q30), kr);
      pitch = vector_angle(kr, -ax * longint'(GAIN_Q30), junk);
      rotate_unit(roll, cr, sr);
      rotate_unit(pitch, cp, sp);
      srsp = floor_sra(sr * sp, 30);
      srcp = floor_sra(sr * cp, 30);
      mx2 = mx * cp + mz * sp;
      my2 = mx * srsp + my * cr - mz * srcp;
      h = vector_angle(mx2, -my2, junk);
      if (h < 0) h += longint'(A360);
      hq = floor_sra(h + 8192, 14);
      if (hq >= HEADING_WRAP) hq -= HEADING_WRAP;
      if (hq < 0) hq = 0;
      r.heading     = 15'(hq);
      r.pitch_angle = 14'(clamp_sym(floor_sra(pitch + 8192, 14), PITCH_MAX));
      r.roll_angle  = 15'(clamp_sym(floor_sra(roll + 8192, 14), ROLL_MAX));
      r.bubble_x    = 16'(level_of(roll));
      r.bubble_y    = 16'(level_of(pitch));
      return r;
   endfunction

   // send one sample, with a random gap first; valid stays high for the next item
   task automatic send_sample(int ax, int ay, int az, int mx, int my, int mz);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.accel_x <= 16'(ax);
      req.accel_y <= 16'(ay);
      req.accel_z <= 16'(az);
      req.mag_x   <= 16'(mx);
      req.mag_y   <= 16'(my);
      req.mag_z   <= 16'(mz);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      attitude_queue.push_back(predict_attitude(longint'(16'sh0 + $signed(16'(ax))),
         $signed(16'(ay)), $signed(16'(az)), $signed(16'(mx)), $signed(16'(my)),
         $signed(16'(mz))));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (attitude_queue.size() != 0) @(negedge clock);
   endtask

   function automatic int rnd16();
      return int'($signed(16'($urandom)));
   endfunction

   // axis extremes, zero vectors and the negative-x half plane
   task automatic test_directed();
      send_sample(0, 0, 0, 0, 0, 0);
      send_sample(1000, 0, 0, 500, 0, 0);
      send_sample(-1000, 0, 0, 500, 0, 0);
      send_sample(0, 0, 1000, 0, 0, 0);
      send_sample(0, 0, -1000, -500, 0, 0);
      send_sample(0, 1000, 0, 0, 500, 0);
      send_sample(0, -1000, 0, 0, -500, 0);
      send_sample(0, 0, 1000, -500, 0, 0);
      send_sample(0, 0, 1000, 500, 0, 0);
      send_sample(0, 0, 1000, 0, 500, 0);
      send_sample(0, 0, 1000, 0, -500, 0);
      send_sample(0, 0, 1000, 500, -1, 0);
      send_sample(32767, 32767, 32767, 32767, 32767, 32767);
      send_sample(-32768, -32768, -32768, -32768, -32768, -32768);
      send_sample(-32768, 0, 0, 0, 0, -32768);
      send_sample(32767, -32768, 32767, -32768, 32767, -32768);
      send_sample(0, 0, -1, 0, 0, 0);
      send_sample(0, 1, 0, 1, 1, 1);
      send_sample(-1, -1, -1, -1, -1, -1);
      send_sample(300, 100, 1000, 200, 100, -400);
      drain_results();
   endtask

   // random samples, mostly near-level tilts plus full-range noise
   task automatic test_random(int count);
      int g;
      for (int n = 0; n < count; n++) begin
         g = $urandom_range(500, 16000);
         if ($urandom_range(0, 3) == 0)
            send_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
         else
            send_sample($urandom_range(0, 2 * g / 2) - g / 2, $urandom_range(0, g) - g / 2,
                        ($urandom_range(0, 1) ? g : -g), rnd16(), rnd16(), rnd16() / 4);
         if (n == count / 2) drain_results();
      end
   endtask

   // result checking and receiver stalls, a random wait before each item
   initial begin
      attitude_type want, got;
      int           wait_n;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         wait_n = $urandom_range(0, 4);
         if (wait_n != 0) begin
            rsp.ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got = '{rsp.heading, rsp.pitch_angle, rsp.roll_angle, rsp.bubble_x, rsp.bubble_y};
         if (attitude_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", got);
         end else begin
            want = attitude_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      {req.accel_x, req.accel_y, req.accel_z} = '0;
      {req.mag_x, req.mag_y, req.mag_z} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1300);
      drain_results();
      repeat (LATENCY + 20) @(negedge clock);
      if (mismatches == 0 && attitude_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
